// ----- hdl/bop_pkg.sv -----
// Shared types and constants for the binomial option pricer.
// No dependencies; every module in hdl imports it.
`timescale 1ns / 1ps
package bop_pkg;
	localparam int MaxSteps = 256;
	localparam int NodeAw = $clog2(MaxSteps + 1);
	localparam int StepW = 9;
	localparam logic [31:0] OneQ30 = 32'h4000_0000;

	typedef enum logic [1:0] {
		ERR_OK     = 2'd0,
		ERR_ZERO   = 2'd1,
		ERR_UPFACT = 2'd2
	} err_code_t;

	typedef struct packed {
		logic [31:0] spot;
		logic [31:0] strike;
		logic [31:0] up_factor;
		logic [30:0] down_factor;
		logic [30:0] up_probability;
		logic [30:0] discount_factor;
		logic [8:0]  step_count;
		logic        is_call;
	} bop_in_t;

	typedef struct packed {
		logic [31:0] price;
		logic [1:0]  error_code;
	} bop_out_t;

	// Classified job handed from front to back.
	typedef struct packed {
		logic [31:0] spot;
		logic [31:0] strike;
		logic [31:0] up_factor;
		logic [30:0] down_factor;
		logic [30:0] prob;
		logic [30:0] discount_factor;
		logic [8:0]  steps;
		logic        is_call;
		err_code_t   err;
	} bop_job_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DOWN, ST_LEAF, ST_IND, ST_DISC, ST_OUT
	} bop_state_t;

	// Q16.16 times Q2.30 with rounding and saturation.
	function automatic logic [31:0] scale_q30(input logic [63:0] prod);
		logic [63:0] r;
		r = (prod + 64'h2000_0000) >> 30;
		return (r[63:32] != 32'd0) ? 32'hFFFF_FFFF : r[31:0];
	endfunction
endpackage

// ----- hdl/bop_front.sv -----
// Front end: accepts input items, classifies errors, resolves depth and probability.
// Depends on bop_pkg.
`timescale 1ns / 1ps
module bop_front import bop_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  bop_in_t    in_data,
	input  logic [8:0] default_steps,
	output logic       job_valid,
	input  logic       job_ready,
	output bop_job_t   job
);
	logic [8:0] n;
	bop_job_t   j;

	always_comb begin
		n = (in_data.step_count == 9'd0) ? default_steps : in_data.step_count;
		if (n == 9'd0) n = 9'd1;
		if ({23'd0, n} > MaxSteps) n = StepW'(MaxSteps);
		j.spot            = in_data.spot;
		j.strike          = in_data.strike;
		j.up_factor       = in_data.up_factor;
		j.down_factor     = in_data.down_factor;
		j.prob            = ({1'b0, in_data.up_probability} > OneQ30) ? OneQ30[30:0]
		                    : in_data.up_probability;
		j.discount_factor = in_data.discount_factor;
		j.steps           = n;
		j.is_call         = in_data.is_call;
		if (in_data.up_factor <= OneQ30) j.err = ERR_UPFACT;
		else if (in_data.spot == 32'd0 || in_data.strike == 32'd0) j.err = ERR_ZERO;
		else j.err = ERR_OK;
	end

	// Two-entry queue decouples acceptance from the sequencer.
	bop_job_t   q_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign job       = q_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = job_valid && job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wp_q] <= j;
	end
endmodule

// ----- hdl/bop_back.sv -----
// Back end: leaf generation, backward induction over a node memory, discounting.
// Depends on bop_pkg.
`timescale 1ns / 1ps
module bop_back import bop_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     job_valid,
	output logic     job_ready,
	input  bop_job_t job,
	output logic     out_valid,
	input  logic     out_ready,
	output bop_out_t out_data
);
	logic [31:0] node_mem [MaxSteps + 1];

	bop_state_t  state_q, state_d;
	bop_job_t    job_q;
	logic [31:0] leaf_q;
	logic [8:0]  lvl_q;
	logic [NodeAw-1:0] idx_q;
	logic        ph_q;
	logic [2:0]  sub_q;
	logic [31:0] a_q, b_q;
	logic [63:0] prod_q, pa_q;
	bop_out_t    res_q;

	logic [31:0] pay;
	logic [30:0] qprob;
	logic [31:0] mem_rd_q;
	logic [31:0] node_new;
	logic        leaf_last, node_last;

	assign qprob = OneQ30[30:0] - job_q.prob;
	assign job_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data  = res_q;
	assign node_new  = 32'((prod_q + pa_q + 64'h2000_0000) >> 30);
	assign leaf_last = ({{(32-NodeAw){1'b0}}, idx_q} == {23'd0, job_q.steps});
	assign node_last = ({{(32-NodeAw){1'b0}}, idx_q} + 32'd1 == {23'd0, lvl_q});

	always_comb begin
		if (job_q.is_call) pay = (leaf_q > job_q.strike) ? leaf_q - job_q.strike : 32'd0;
		else pay = (job_q.strike > leaf_q) ? job_q.strike - leaf_q : 32'd0;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (job_valid) state_d = (job.err != ERR_OK) ? ST_OUT : ST_DOWN;
			ST_DOWN: if (ph_q && lvl_q == 9'd1) state_d = ST_LEAF;
			ST_LEAF: if (sub_q == 3'd0 && leaf_last) state_d = ST_IND;
			ST_IND:  if (sub_q == 3'd4 && node_last && lvl_q == 9'd1) state_d = ST_DISC;
			ST_DISC: if (ph_q) state_d = ST_OUT;
			ST_OUT:  if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Phased micro-steps: the multiplier is registered before scaling.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= 1'b0;
			sub_q   <= 3'd0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					ph_q <= 1'b0;
					sub_q <= 3'd0;
				end
				ST_DOWN: begin
					ph_q <= ~ph_q;
					if (state_d == ST_LEAF) sub_q <= 3'd0;
				end
				ST_LEAF: begin
					// sub 0 write leaf; 1,2 first up mult; 3,4 second
					if (sub_q == 3'd0) sub_q <= leaf_last ? 3'd0 : 3'd1;
					else if (sub_q == 3'd4) sub_q <= 3'd0;
					else sub_q <= sub_q + 3'd1;
				end
				ST_IND: begin
					// 0 read i,1 read i+1,2 latch,3 mult,4 add/write
					if (sub_q == 3'd4) begin
						sub_q <= 3'd0;
						if (state_d == ST_DISC) ph_q <= 1'b0;
					end else sub_q <= sub_q + 3'd1;
				end
				ST_DISC: ph_q <= ~ph_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (job_valid) begin
				job_q  <= job;
				leaf_q <= job.spot;
				lvl_q  <= job.steps;
				idx_q  <= '0;
				res_q  <= '{price: 32'd0, error_code: job.err};
			end
			ST_DOWN: begin
				if (!ph_q) prod_q <= leaf_q * {33'd0, job_q.down_factor};
				else begin
					leaf_q <= scale_q30(prod_q);
					if (lvl_q == 9'd1) lvl_q <= job_q.steps;
					else lvl_q <= lvl_q - 9'd1;
				end
			end
			ST_LEAF: begin
				unique case (sub_q)
					3'd0: begin
						node_mem[idx_q] <= pay;
						if (leaf_last) idx_q <= '0;
						else idx_q <= idx_q + 1'b1;
					end
					3'd1, 3'd3: prod_q <= leaf_q * {32'd0, job_q.up_factor};
					3'd2, 3'd4: leaf_q <= scale_q30(prod_q);
					default: ;
				endcase
			end
			ST_IND: begin
				unique case (sub_q)
					3'd0: mem_rd_q <= node_mem[idx_q];
					3'd1: begin
						a_q <= mem_rd_q;
						mem_rd_q <= node_mem[idx_q + 1'b1];
					end
					3'd2: b_q <= mem_rd_q;
					3'd3: begin
						prod_q <= b_q * {33'd0, job_q.prob};
						pa_q   <= a_q * {33'd0, qprob};
					end
					3'd4: begin
						// keep the fresh node; after the last level it is the root
						node_mem[idx_q] <= node_new;
						mem_rd_q <= node_new;
						if (node_last) begin
							idx_q <= '0;
							lvl_q <= lvl_q - 9'd1;
						end else idx_q <= idx_q + 1'b1;
					end
					default: ;
				endcase
			end
			ST_DISC: begin
				if (!ph_q) prod_q <= mem_rd_q * {33'd0, job_q.discount_factor};
				else res_q <= '{price: scale_q30(prod_q), error_code: ERR_OK};
			end
			default: ;
		endcase
	end
endmodule

// ----- hdl/binomial_option_pricer_unit.sv -----
// Top level of the binomial option pricer: front queue plus sequencing back end.
// Depends on bop_pkg, bop_front, bop_back.
`timescale 1ns / 1ps
// One European option is priced per item on an N-step Cox-Ross-Rubinstein tree.
// The back end works one multiply step at a time (two 32x31 products side by
// side during induction) over one node memory: down moves, leaves, induction,
// then discount and handoff. Error items skip straight to handoff. A two-entry
// queue in front lets new items be accepted while the back end is busy.
module binomial_option_pricer_unit import bop_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  bop_in_t    in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output bop_out_t   out_data
);
	logic [8:0] default_steps_q;
	logic       job_valid, job_ready;
	bop_job_t   job;

	// hold the default depth register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) default_steps_q <= 9'd128;
		else if (cfg_we) default_steps_q <= cfg_wdata;
	end

	bop_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.default_steps(default_steps_q), .job_valid, .job_ready, .job
	);

	bop_back u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job,
		.out_valid, .out_ready, .out_data
	);
endmodule

// ----- tb/sv/binomial_option_pricer_unit_test.sv -----
// Self-checking test of binomial_option_pricer_unit: bit-exact pricing predictor,
// bursty sender, stalling receiver. Depends on bop_pkg and the unit's RTL.
`timescale 1ns / 1ps

// Holds the expected quotes and the pricer's copy of the step-count register.
class price_ledger;
	bop_pkg::bop_out_t pending[$];
	logic [8:0] default_depth = 9'd128;
	int mismatches = 0;

	// Q16.16 value times a Q2.30 factor, rounded half up, saturated.
	static function logic [31:0] mul_q30(logic [31:0] v, logic [31:0] f);
		logic [63:0] prod;
		prod = ({32'd0, v} * {32'd0, f} + 64'h2000_0000) >> 30;
		return (prod[63:32] != 32'd0) ? 32'hFFFF_FFFF : prod[31:0];
	endfunction

	// Price one option exactly as the block does.
	function bop_pkg::bop_out_t price_option(bop_pkg::bop_in_t it);
		bop_pkg::bop_out_t q;
		logic [31:0] tree [0:bop_pkg::MaxSteps];
		logic [31:0] leaf, p, pq;
		logic [63:0] acc;
		int depth;
		q.price = 32'd0;
		if (it.up_factor <= bop_pkg::OneQ30) begin
			q.error_code = bop_pkg::ERR_UPFACT;
			return q;
		end
		if (it.spot == 32'd0 || it.strike == 32'd0) begin
			q.error_code = bop_pkg::ERR_ZERO;
			return q;
		end
		depth = (it.step_count == 9'd0) ? default_depth : it.step_count;
		if (depth == 0) depth = 1;
		if (depth > bop_pkg::MaxSteps) depth = bop_pkg::MaxSteps;
		p = ({1'b0, it.up_probability} > bop_pkg::OneQ30) ? bop_pkg::OneQ30
			: {1'b0, it.up_probability};
		pq = bop_pkg::OneQ30 - p;
		// Walk down to the lowest leaf, then climb by u twice per leaf.
		leaf = it.spot;
		for (int i = 0; i < depth; i++) leaf = mul_q30(leaf, {1'b0, it.down_factor});
		for (int j = 0; j <= depth; j++) begin
			if (j > 0) leaf = mul_q30(mul_q30(leaf, it.up_factor), it.up_factor);
			if (it.is_call) tree[j] = (leaf > it.strike) ? leaf - it.strike : 32'd0;
			else tree[j] = (it.strike > leaf) ? it.strike - leaf : 32'd0;
		end
		for (int lvl = depth; lvl > 0; lvl--) begin
			for (int i = 0; i < lvl; i++) begin
				acc = {32'd0, p} * {32'd0, tree[i+1]} + {32'd0, pq} * {32'd0, tree[i]}
					+ 64'h2000_0000;
				tree[i] = acc[61:30];
			end
		end
		q.price = mul_q30(tree[0], {1'b0, it.discount_factor});
		q.error_code = bop_pkg::ERR_OK;
		return q;
	endfunction

	function void note_order(bop_pkg::bop_in_t it);
		pending = {pending, price_option(it)};
	endfunction

	function void check_quote(bop_pkg::bop_out_t got);
		bop_pkg::bop_out_t want;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected quote: price %h code %0d", got.price, got.error_code);
			return;
		end
		want = pending.pop_front();
		if (got.price !== want.price || got.error_code !== want.error_code) begin
			mismatches++;
			if (mismatches <= 10)
				$display("quote mismatch: expected price %h code %0d, got price %h code %0d",
					want.price, want.error_code, got.price, got.error_code);
		end
	endfunction
endclass

module binomial_option_pricer_unit_test;
	import bop_pkg::*;

	localparam int StallLimit = 500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [8:0] cfg_wdata = 9'd0;
	logic in_valid = 1'b0;
	logic in_ready;
	bop_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	bop_out_t out_data;

	price_ledger ledger = new();
	int idle_cycles = 0;
	int rx_mode = 0;
	int rx_count = 0;

	binomial_option_pricer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Log accepted items and check quotes; values read here are pre-edge values.
	always @(posedge clk) begin
		if (in_valid && in_ready) ledger.note_order(in_data);
		if (out_valid && out_ready) ledger.check_quote(out_data);
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= StallLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: when its countdown runs out, pick anew among always ready, coin flip,
	// and mostly stalled, so back-pressure reaches the back end and the front queue.
	always @(posedge clk) begin
		if (rx_count == 0) begin
			rx_mode <= $urandom_range(0, 2);
			rx_count <= 64;
		end else begin
			rx_count <= rx_count - 1;
		end
		case (rx_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= 1'($urandom_range(0, 1));
			end
			default: begin
				out_ready <= ($urandom_range(0, 7) == 0);
			end
		endcase
	end

	// Present one item and hold it until accepted; valid stays high afterwards.
	task automatic send_order(bop_in_t it);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid for a random gap, or keep bursting.
	task automatic maybe_gap();
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every quote has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (ledger.pending.size() != 0) @(posedge clk);
	endtask

	// Write the default tree depth while the block is idle.
	task automatic set_default_depth(logic [8:0] depth);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= depth;
		@(posedge clk);
		cfg_we <= 1'b0;
		ledger.default_depth = depth;
	endtask

	function automatic bop_in_t plain_order(logic [8:0] steps, logic call);
		bop_in_t it;
		it.spot = 32'h0064_0000;
		it.strike = 32'h0064_0000;
		it.up_factor = 32'h4200_0000;
		it.down_factor = 31'h3E0F_83E1;
		it.up_probability = 31'h2000_0000;
		it.discount_factor = 31'h3F00_0000;
		it.step_count = steps;
		it.is_call = call;
		return it;
	endfunction

	// Well-formed option with random content; now and then raw noise fields.
	function automatic bop_in_t random_order();
		bop_in_t it;
		logic [63:0] inv;
		it.up_factor = OneQ30 + $urandom_range(1, 32'h0400_0000);
		inv = 64'h1000_0000_0000_0000 / it.up_factor;
		it.down_factor = inv[30:0];
		it.spot = $urandom_range(32'h0001_0000, 32'h0400_0000);
		it.strike = it.spot + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
		it.up_probability = 31'($urandom_range(0, 32'h4000_0000));
		it.discount_factor = 31'($urandom_range(32'h3000_0000, 32'h4000_0000));
		it.step_count = 9'($urandom_range(0, 24));
		it.is_call = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0: it.spot = $urandom();
			1: it.strike = $urandom();
			2: it.up_factor = $urandom();
			3: it.down_factor = 31'($urandom());
			4: it.up_probability = 31'($urandom());
			5: it.discount_factor = 31'($urandom());
			6: it.spot = 32'd0;
			default: ;
		endcase
		return it;
	endfunction

	initial begin
		bop_in_t it;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: error codes and their precedence.
		it = plain_order(9'd2, 1'b1); it.up_factor = OneQ30; it.spot = 32'd0;
		send_order(it);
		it = plain_order(9'd2, 1'b0); it.up_factor = 32'd0;
		send_order(it);
		it = plain_order(9'd2, 1'b1); it.spot = 32'd0;
		send_order(it);
		it = plain_order(9'd2, 1'b0); it.strike = 32'd0;
		send_order(it);
		// Plain call and put at the shallowest tree, then a call at depth 6.
		send_order(plain_order(9'd1, 1'b1));
		send_order(plain_order(9'd1, 1'b0));
		send_order(plain_order(9'd6, 1'b1));
		// Saturation with spot or strike, the up and down factors and the discount at their top values.
		it = plain_order(9'd3, 1'b1);
		it.spot = 32'hFFFF_FFFF; it.strike = 32'd1; it.up_factor = 32'hFFFF_FFFF;
		it.down_factor = 31'h7FFF_FFFF; it.discount_factor = 31'h7FFF_FFFF;
		send_order(it);
		it.is_call = 1'b0; it.strike = 32'hFFFF_FFFF; it.spot = 32'd1;
		send_order(it);
		// Probability above one is clamped; then zero probability with zero discount.
		it = plain_order(9'd4, 1'b1); it.up_probability = 31'h7FFF_FFFF;
		send_order(it);
		it = plain_order(9'd4, 1'b0); it.up_probability = 31'd0;
		it.discount_factor = 31'd0;
		send_order(it);
		// Zero depth takes the reset default; oversize depth is cut to the maximum.
		send_order(plain_order(9'd0, 1'b0));
		send_order(plain_order(9'h1FF, 1'b1));

		// Random phases over several default depths, extremes included.
		set_default_depth(9'd1);
		for (int n = 0; n < 40; n++) begin
			send_order(random_order());
			maybe_gap();
		end
		set_default_depth(9'd256);
		send_order(plain_order(9'd0, 1'b1));
		set_default_depth(9'd0);
		for (int n = 0; n < 30; n++) begin
			send_order(random_order());
			maybe_gap();
		end
		set_default_depth(9'd7);
		for (int n = 0; n < 30; n++) begin
			send_order(random_order());
			maybe_gap();
		end

		drain();
		repeat (20) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// ----- files.f -----
hdl/bop_pkg.sv
hdl/bop_front.sv
hdl/bop_back.sv
hdl/binomial_option_pricer_unit.sv
tb/sv/binomial_option_pricer_unit_test.sv
